>>> design/rcc_pkg.sv
// ----------------------------------------------------------------------------
// rcc_pkg - shared types and constants for the RGBW colour correction block
// Pixel and numerator bundles, configuration register indexes, divider
// reciprocal and clamp limit.
// ----------------------------------------------------------------------------
package rcc_pkg;

  typedef logic [7:0] chan_t;

  // packed so that red sits in the lowest byte
  typedef struct packed {
    chan_t white;
    chan_t blue;
    chan_t green;
    chan_t red;
  } pixel_t;

  // numerator over 60000, signed, wide enough for every corner of the range
  typedef logic signed [26:0] num_t;

  typedef struct packed {
    num_t white;
    num_t blue;
    num_t green;
    num_t red;
  } num_bundle_t;

  typedef struct packed {
    logic [6:0]        brightness;
    logic [6:0]        saturation;
    logic signed [7:0] temperature;
  } cfg_t;

  typedef enum logic [1:0] {
    CFG_BRIGHTNESS  = 2'd0,
    CFG_SATURATION  = 2'd1,
    CFG_TEMPERATURE = 2'd2
  } cfg_idx_t;

  // floor(n / 60000) == (n * DIV_RECIP) >> DIV_SHIFT for every n < 2^24
  localparam logic [24:0] DIV_RECIP = 25'd18325194;
  localparam int          DIV_SHIFT = 40;
  // 256 * 60000: at or above this the channel saturates
  localparam logic [23:0] CLAMP_LIM = 24'd15360000;

  localparam logic [6:0]        BRIGHT_RST = 7'd100;
  localparam logic [6:0]        SAT_RST    = 7'd100;
  localparam logic signed [7:0] TEMP_RST   = 8'sd0;

endpackage

>>> design/rcc_mix.sv
// ----------------------------------------------------------------------------
// rcc_mix - numerator pipeline
// Three register stages: gain and white products, per-channel products,
// then the four numerators over 60000.
// ----------------------------------------------------------------------------
module rcc_mix (
  input  logic                clk,
  input  logic                en,
  input  rcc_pkg::pixel_t     pix,
  input  rcc_pkg::cfg_t       cfg,
  output rcc_pkg::num_bundle_t num
);
  import rcc_pkg::*;

  // stage 1
  chan_t             r1_r, g1_r, b1_r;
  logic [13:0]       bs1_r;
  logic [15:0]       wt1_r;
  logic [14:0]       wb1_r;
  logic [9:0]        sum1_r;
  logic signed [7:0] desat1_r;
  logic              warm1_r, cool1_r;
  logic [7:0]        tabs;

  // stage 2
  logic [21:0]        rbs2_r, gbs2_r, bbs2_r;
  logic [15:0]        wt2_r;
  logic [14:0]        wb2_r;
  logic signed [17:0] sdes2_r;
  logic               warm2_r, cool2_r;

  // stage 3
  logic [25:0] nr, ng, nb;
  num_t        nw;
  num_bundle_t num_r;

  // |T|, -128 gives 128
  assign tabs = cfg.temperature[7] ? 8'(-cfg.temperature) : 8'(cfg.temperature);

  always_ff @(posedge clk) begin
    if (en) begin
      r1_r     <= pix.red;
      g1_r     <= pix.green;
      b1_r     <= pix.blue;
      bs1_r    <= cfg.brightness * cfg.saturation;
      wt1_r    <= pix.white * tabs;
      wb1_r    <= pix.white * cfg.brightness;
      sum1_r   <= 10'(pix.red) + 10'(pix.green) + 10'(pix.blue);
      desat1_r <= 8'sd100 - $signed({1'b0, cfg.saturation});
      warm1_r  <= !cfg.temperature[7] && (cfg.temperature != 8'sd0);
      cool1_r  <= cfg.temperature[7];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rbs2_r  <= r1_r * bs1_r;
      gbs2_r  <= g1_r * bs1_r;
      bbs2_r  <= b1_r * bs1_r;
      wt2_r   <= wt1_r;
      wb2_r   <= wb1_r;
      sdes2_r <= $signed({1'b0, sum1_r}) * desat1_r;
      warm2_r <= warm1_r;
      cool2_r <= cool1_r;
    end
  end

  // constant scalings only: shift-and-add
  always_comb begin
    nr = 26'(rbs2_r) * 26'd6 + (warm2_r ? 26'(wt2_r) * 26'd300 : 26'd0);
    ng = 26'(gbs2_r) * 26'd6 + (warm2_r ? 26'(wt2_r) * 26'd150 : 26'd0);
    nb = 26'(bbs2_r) * 26'd6 + (cool2_r ? 26'(wt2_r) * 26'd100 : 26'd0);
    nw = num_t'(wb2_r) * num_t'(600) + num_t'(sdes2_r) * num_t'(200)
       - num_t'(wt2_r) * num_t'(100);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_r.red   <= $signed({1'b0, nr});
      num_r.green <= $signed({1'b0, ng});
      num_r.blue  <= $signed({1'b0, nb});
      num_r.white <= nw;
    end
  end

  assign num = num_r;

endmodule

>>> design/rcc_div.sv
// ----------------------------------------------------------------------------
// rcc_div - divide by 60000 with floor and saturation
// Two stages: range check, then reciprocal multiply; quotient picked after.
// ----------------------------------------------------------------------------
module rcc_div (
  input  logic          clk,
  input  logic          en,
  input  rcc_pkg::num_t num,
  output rcc_pkg::chan_t q
);
  import rcc_pkg::*;

  logic        neg1_r, ovf1_r;
  logic [23:0] n1_r;
  logic        neg2_r, ovf2_r;
  logic [48:0] prod2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      neg1_r <= num[26];
      ovf1_r <= !num[26] && (num[25:24] != 2'b00 || num[23:0] >= CLAMP_LIM);
      n1_r   <= num[23:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg2_r  <= neg1_r;
      ovf2_r  <= ovf1_r;
      prod2_r <= n1_r * DIV_RECIP;
    end
  end

  always_comb begin
    if (neg2_r) begin
      q = 8'd0;
    end else if (ovf2_r) begin
      q = 8'd255;
    end else begin
      q = prod2_r[DIV_SHIFT+7:DIV_SHIFT];
    end
  end

endmodule

>>> design/rgbw_color_correction.sv
// ----------------------------------------------------------------------------
// rgbw_color_correction - RGBW pixel colour correction, one item per clock
// Brightness, saturation and colour temperature applied to a pixel stream.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : slave stream, one RGBW pixel per item (red in the lowest byte).
//   out_* : master stream, one corrected RGBW pixel per accepted item.
//   cfg_* : write-only registers, 0 brightness, 1 saturation,
//           2 temperature (two's complement); index 3 is ignored.
//           Write only while the pipe is empty.
// Throughput: one item per clock; set by the six-register pipe
//   (three numerator stages, two divider stages, output register).
// The whole pipe advances together on one enable; when the receiver holds
//   out_tready low with a result waiting, every stage freezes and in_tready
//   drops, so nothing is lost or repeated. Bubbles do not advance while
//   frozen.
// Reset: registers return to brightness 100, saturation 100,
//   temperature 0; all valid bits clear.
// ----------------------------------------------------------------------------
module rgbw_color_correction (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [7:0]  cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // red[7:0] green[15:8] blue[23:16] white[31:24]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // red[7:0] green[15:8] blue[23:16] white[31:24]
);
  import rcc_pkg::*;

  localparam int NSTG = 5;  // stages ahead of the output register

  cfg_t         cfg_r, cfg_nxt;
  logic         en;
  logic [NSTG-1:0] vld_r, vld_nxt;
  logic         out_valid_r, out_valid_nxt;
  pixel_t       out_pix_r;
  pixel_t       pix_in, pix_q;
  num_bundle_t  num;

  // ---- configuration registers ----
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_idx_t'(cfg_addr))
        CFG_BRIGHTNESS:  cfg_nxt.brightness  = cfg_wdata[6:0];
        CFG_SATURATION:  cfg_nxt.saturation  = cfg_wdata[6:0];
        CFG_TEMPERATURE: cfg_nxt.temperature = $signed(cfg_wdata);
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.brightness  <= BRIGHT_RST;
      cfg_r.saturation  <= SAT_RST;
      cfg_r.temperature <= TEMP_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // ---- pipe enable: free output slot or result being taken ----
  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;

  assign pix_in = pixel_t'(in_tdata);

  rcc_mix u_mix (
    .clk (clk),
    .en  (en),
    .pix (pix_in),
    .cfg (cfg_r),
    .num (num)
  );

  rcc_div u_div_r (.clk(clk), .en(en), .num(num.red),   .q(pix_q.red));
  rcc_div u_div_g (.clk(clk), .en(en), .num(num.green), .q(pix_q.green));
  rcc_div u_div_b (.clk(clk), .en(en), .num(num.blue),  .q(pix_q.blue));
  rcc_div u_div_w (.clk(clk), .en(en), .num(num.white), .q(pix_q.white));

  // ---- valid bits travel with the data ----
  always_comb begin
    vld_nxt       = vld_r;
    out_valid_nxt = out_valid_r;
    if (en) begin
      vld_nxt       = {vld_r[NSTG-2:0], in_tvalid};
      out_valid_nxt = vld_r[NSTG-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      vld_r       <= vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_pix_r <= pix_q;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_pix_r;

  // ---- assertions ----
  a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |=> ($stable(vld_r) && $stable(out_pix_r)))
    else $error("pipe moved while output stalled");

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> vld_r[0])
    else $error("accepted item missing from first stage");

  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(vld_r[NSTG-1]))
    else $error("output valid without item in last stage");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> (!out_valid_r && (vld_r == '0)))
    else $error("valid bits not cleared by reset");

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb - self-checking bench for rgbw_color_correction
// Streams RGBW pixels through the block under several register settings,
// predicts every corrected pixel in the bench and compares each output item,
// field by field, against the oldest outstanding prediction. Sender bursts,
// receiver stall patterns and long hold-offs exercise the stream handshakes.
// ----------------------------------------------------------------------------
module tb;
  import rcc_pkg::*;

  // fixed point: each channel is an integer numerator over 60000
  localparam int LEVEL_DENOM = 60000;
  localparam int LEVEL_MAX   = 255;
  // register index with no register behind it, writes must be dropped
  localparam logic [1:0] CFG_UNUSED = 2'd3;
  localparam int HOLDOFF_CYCLES = 300;
  localparam int SETTLE_CYCLES  = 20;    // idle wait after the last result, before the verdict
  localparam int CYCLE_LIMIT    = 500000;
  localparam int RANDOM_PHASES  = 8;
  localparam int PHASE_ITEMS    = 170;

  typedef enum logic {RX_ALWAYS, RX_PATTERN} rx_mode_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_addr = 2'd0;
  logic [7:0]  cfg_wdata = 8'd0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = 32'd0;    // red[7:0] green[15:8] blue[23:16] white[31:24]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;           // red[7:0] green[15:8] blue[23:16] white[31:24]

  rgbw_color_correction uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // bench copy of the registers, tracks every write made through write_reg
  logic [6:0]        bright_pct = BRIGHT_RST;
  logic [6:0]        sat_pct    = SAT_RST;
  logic signed [7:0] temp_shift = TEMP_RST;

  pixel_t pending_pixels[$];   // predicted outputs, oldest first
  int     error_count = 0;
  int     cycle_count = 0;

  // sender pacing: gap_max of 0 means back-to-back items
  int burst_left = 0;
  int gap_max    = 0;

  // receiver control, written by the tests
  rx_mode_t ready_mode    = RX_PATTERN;
  int       holdoff_token = 0;

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------
  function automatic chan_t clamp_level(int num);
    int q;
    if (num < 0) return 8'd0;
    q = num / LEVEL_DENOM;
    if (q > LEVEL_MAX) return 8'd255;
    return q[7:0];
  endfunction

  function automatic pixel_t correct_pixel(pixel_t px);
    int r, g, b, w, bri, sat, t, tmag, gain;
    int nr, ng, nb, nw;
    pixel_t res;
    r = px.red;
    g = px.green;
    b = px.blue;
    w = px.white;
    bri = bright_pct;
    sat = sat_pct;
    t = temp_shift;
    tmag = (t < 0) ? -t : t;
    gain = 6 * bri * sat;
    nr = r * gain;
    ng = g * gain;
    nb = b * gain;
    // warm pushes white into red and green, cool into blue
    if (t > 0) begin
      nr += 300 * w * t;
      ng += 150 * w * t;
    end
    if (t < 0) nb += 100 * w * tmag;
    // desaturation goes negative above 100 percent and eats into white
    nw = 600 * w * bri + 200 * (r + g + b) * (100 - sat) - 100 * w * tmag;
    res.red   = clamp_level(nr);
    res.green = clamp_level(ng);
    res.blue  = clamp_level(nb);
    res.white = clamp_level(nw);
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------
  task automatic report_error(string msg);
    $display("ERROR @%0t: %s", $time, msg);
    error_count++;
  endtask

  always @(posedge clk) begin : result_check
    pixel_t got, want;
    string  chan_names[4];
    chan_names = '{"red", "green", "blue", "white"};
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (pending_pixels.size() == 0) begin
        report_error($sformatf("result %08h with no item outstanding", got));
      end else begin
        want = pending_pixels.pop_front();
        for (int i = 0; i < 4; i++) begin
          if (got[i*8 +: 8] !== want[i*8 +: 8])
            report_error($sformatf("%s got %0d expected %0d (pixel got %08h want %08h)",
                                   chan_names[i], got[i*8 +: 8], want[i*8 +: 8],
                                   got, want));
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: rotating 16-bit ready mask, reloaded whenever the phase counter wraps;
  // an all-ones mask gives stretches with no stalls. A new hold-off token forces a long
  // stretch of ready low, counted here.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : receiver
    static int          holdoff_seen = 0;
    static int          stall_left   = 0;
    static int          phase        = 0;
    static logic [15:0] ready_mask   = 16'hFFFF;
    if (holdoff_token != holdoff_seen) begin
      holdoff_seen = holdoff_token;
      stall_left = HOLDOFF_CYCLES;
    end
    if (phase == 0) begin
      case ($urandom_range(0, 3))
        0: ready_mask = 16'hFFFF;
        1: ready_mask = 16'($urandom) | 16'($urandom);
        default: ready_mask = 16'($urandom) | (16'd1 << $urandom_range(0, 15));
      endcase
    end
    phase = (phase + 1) % 64;
    if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else if (ready_mode == RX_ALWAYS) begin
      out_tready <= 1'b1;
    end else begin
      out_tready <= ready_mask[phase % 16];
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d items outstanding",
               cycle_count, pending_pixels.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Shared helpers
  // --------------------------------------------------------------------------
  function automatic pixel_t make_pixel(int r, int g, int b, int w);
    pixel_t px;
    px.red   = r[7:0];
    px.green = g[7:0];
    px.blue  = b[7:0];
    px.white = w[7:0];
    return px;
  endfunction

  // channels lean on the extremes a quarter of the time
  function automatic chan_t rand_level();
    case ($urandom_range(0, 7))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic pixel_t rand_pixel();
    return make_pixel(rand_level(), rand_level(), rand_level(), rand_level());
  endfunction

  // holds the item until taken, then records its prediction; valid stays high
  // so a following call keeps streaming without a bubble
  task automatic send_pixel(pixel_t px);
    in_tdata  <= px;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    pending_pixels.push_back(correct_pixel(px));
  endtask

  // send plus burst/gap pacing
  task automatic offer_pixel(pixel_t px);
    send_pixel(px);
    if (gap_max > 0) begin
      if (burst_left == 0) begin
        in_tvalid <= 1'b0;
        in_tdata  <= $urandom;
        repeat ($urandom_range(1, gap_max)) @(posedge clk);
        burst_left = $urandom_range(1, 16);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic wait_results_drained();
    in_tvalid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
  endtask

  // only called with the pipe empty
  task automatic write_reg(logic [1:0] idx, logic [7:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_BRIGHTNESS:  bright_pct = val[6:0];
      CFG_SATURATION:  sat_pct    = val[6:0];
      CFG_TEMPERATURE: temp_shift = val;
      default: ;
    endcase
  endtask

  task automatic set_config(int bri, int sat, int t);
    wait_results_drained();
    write_reg(CFG_BRIGHTNESS, {1'($urandom), bri[6:0]});
    write_reg(CFG_SATURATION, {1'($urandom), sat[6:0]});
    write_reg(CFG_TEMPERATURE, t[7:0]);
  endtask

  function automatic int rand_percent();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return 100;
      2: return 127;
      default: return $urandom_range(0, 127);
    endcase
  endfunction

  function automatic int rand_temperature();
    case ($urandom_range(0, 6))
      0: return -128;
      1: return 127;
      2: return 0;
      3: return $urandom_range(0, 1) ? 100 : -100;
      default: return int'($urandom_range(0, 255)) - 128;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // reset values 100/100/0: pixels pass through unchanged
  task automatic test_reset_defaults();
    gap_max = 0;
    send_pixel(make_pixel(0, 0, 0, 0));
    send_pixel(make_pixel(255, 255, 255, 255));
    send_pixel(make_pixel(255, 0, 0, 0));
    send_pixel(make_pixel(0, 255, 0, 0));
    send_pixel(make_pixel(0, 0, 255, 0));
    send_pixel(make_pixel(0, 0, 0, 255));
    send_pixel(make_pixel(1, 2, 3, 4));
  endtask

  task automatic test_config_extremes();
    // gain above one: full-scale channels saturate, mid levels scale up
    set_config(127, 100, 0);
    send_pixel(make_pixel(255, 255, 255, 255));
    send_pixel(make_pixel(100, 100, 100, 100));
    // saturation above 100: white pulled down, floors at zero
    set_config(50, 127, 0);
    send_pixel(make_pixel(255, 255, 255, 10));
    send_pixel(make_pixel(10, 10, 10, 255));
    // fully desaturated: RGB mean lands in white
    set_config(100, 0, 0);
    send_pixel(make_pixel(255, 255, 255, 0));
    // warm beyond 100 with zero brightness: red and green keep only the white push
    set_config(0, 0, 127);
    send_pixel(make_pixel(0, 0, 0, 255));
    send_pixel(make_pixel(255, 255, 255, 255));
    // coolest setting
    set_config(100, 100, -128);
    send_pixel(make_pixel(0, 0, 0, 255));
    send_pixel(make_pixel(255, 255, 255, 255));
    set_config(100, 100, 100);
    send_pixel(make_pixel(200, 100, 50, 255));
    set_config(100, 100, -100);
    send_pixel(make_pixel(200, 100, 50, 255));
    // write to the unused index must leave the settings alone
    wait_results_drained();
    write_reg(CFG_UNUSED, 8'hFF);
    send_pixel(make_pixel(128, 64, 32, 200));
  endtask

  task automatic test_random_settings();
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      set_config(rand_percent(), rand_percent(), rand_temperature());
      if ($urandom_range(0, 2) == 0) write_reg(CFG_UNUSED, 8'($urandom));
      case (p % 3)
        0: gap_max = 0;
        1: gap_max = 3;
        default: gap_max = 12;
      endcase
      burst_left = $urandom_range(1, 16);
      for (int i = 0; i < PHASE_ITEMS; i++) offer_pixel(rand_pixel());
    end
  endtask

  // receiver holds off long enough for the pipe to fill and stall the input
  task automatic test_backpressure();
    for (int k = 0; k < 2; k++) begin
      set_config(rand_percent(), rand_percent(), rand_temperature());
      gap_max = 0;
      @(negedge clk);
      holdoff_token++;
      @(posedge clk);
      for (int i = 0; i < 80; i++) send_pixel(rand_pixel());
      // sender pauses until every result is back
      wait_results_drained();
    end
  endtask

  // one item per clock both sides, no idling at all
  task automatic test_full_rate();
    set_config(rand_percent(), rand_percent(), rand_temperature());
    ready_mode = RX_ALWAYS;
    gap_max = 0;
    for (int i = 0; i < 120; i++) send_pixel(rand_pixel());
    wait_results_drained();
    ready_mode = RX_PATTERN;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_config_extremes();
    test_random_settings();
    test_backpressure();
    test_full_rate();
    wait_results_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
